// ===== rtl/ltab_pkg.sv =====
// shared types and constants of the link table block
`timescale 1ns / 1ps

package ltab_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int ENTRY_W   = 2 * NODE_W;
    localparam int ENTRIES   = MAX_NODES * MAX_NODES;
    localparam int CNT_W     = 5;
    localparam int COST_W    = 32;
    localparam int PROD_W    = 2 * COST_W;
    localparam int TIME_W    = 63;
    localparam int TOTAL_W   = 32;

    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // operation codes
    typedef logic [1:0] op_t;
    localparam op_t OP_CONNECT = 2'd0;
    localparam op_t OP_QUERY   = 2'd1;
    localparam op_t OP_LIST    = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONN2,
        ST_QREAD,
        ST_QWAIT,
        ST_LIST,
        ST_EMIT
    } state_t;

    // request into the cost unit
    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] alpha;
        logic [COST_W-1:0] beta;
        logic [COST_W-1:0] chunk;
    } cost_req_t;

    // answer from the cost unit
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] xfer_time;
    } cost_rsp_t;

endpackage

// ===== rtl/ltab_if.sv =====
// channel interfaces of the link table block
`timescale 1ns / 1ps

// operation requests
interface ltab_req_if;
    import ltab_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;
    logic              both_ways;
    logic [COST_W-1:0] fixed_latency;
    logic [COST_W-1:0] per_unit_cost;
    logic [COST_W-1:0] chunk_units;

    modport source (
        output valid, operation, source_node, target_node, both_ways,
               fixed_latency, per_unit_cost, chunk_units,
        input  ready
    );
    modport sink (
        input  valid, operation, source_node, target_node, both_ways,
               fixed_latency, per_unit_cost, chunk_units,
        output ready
    );
endinterface

// result items
interface ltab_rsp_if;
    import ltab_pkg::*;
    logic               valid;
    logic               ready;
    logic               link_present;
    logic [TIME_W-1:0]  transfer_time;
    logic [NODE_W-1:0]  found_source;
    logic [TOTAL_W-1:0] link_total;
    logic               bad_id;
    logic               last_result;

    modport source (
        output valid, link_present, transfer_time, found_source, link_total,
               bad_id, last_result,
        input  ready
    );
    modport sink (
        input  valid, link_present, transfer_time, found_source, link_total,
               bad_id, last_result,
        output ready
    );
endinterface

// node count register writes
interface ltab_cfg_if;
    import ltab_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] node_count;

    modport source (output valid, node_count, input ready);
    modport sink   (input valid, node_count, output ready);
endinterface

// ===== rtl/ltab_cost.sv =====
// two-stage alpha plus beta times chunk unit with saturation
`timescale 1ns / 1ps

module ltab_cost (
    input  logic               clk,
    input  logic               rst_n,
    input  ltab_pkg::cost_req_t request,
    output ltab_pkg::cost_rsp_t result
);
    import ltab_pkg::*;

    logic                v1_reg;
    logic                v2_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [COST_W-1:0]   alpha_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [PROD_W:0]     sum;
    logic [TIME_W-1:0]   time_next;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= request.valid;
            v2_reg <= v1_reg;
        end
    end

    // stage one: product
    always_ff @(posedge clk)
    begin
        if (request.valid)
        begin
            prod_reg  <= PROD_W'(request.beta) * PROD_W'(request.chunk);
            alpha_reg <= request.alpha;
        end
    end

    // stage two: add alpha and saturate into 63 bits
    always_comb
    begin
        sum = {1'b0, prod_reg} + (PROD_W + 1)'(alpha_reg);
        if (sum[PROD_W:TIME_W] != '0)
            time_next = TIME_MAX;
        else
            time_next = sum[TIME_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
            time_reg <= time_next;
    end

    assign result.valid     = v2_reg;
    assign result.xfer_time = time_reg;

endmodule

// ===== rtl/link_table_with_alpha_beta_cost_unit.sv =====
// Link table of 16 x 16 directed node pairs with alpha-beta link cost.
//
// Channels: req carries one operation (connect, query link, list incoming
// sources of a destination); rsp returns its result items; cfg writes the
// node count, which clears every present bit but keeps the link counter.
// All transfers complete on a rising clk edge with valid and ready high.
// Items are handled one at a time by a sequencer around a 256 x 64 cost
// memory (read through a register) and a row of 256 present bits.
// Steps from accept to the result register: connect writes the memory,
// connect both ways also writes the reverse direction, query reads the
// memory and then runs the two-stage multiply and saturating add, list walks
// node_count sources however many are found. An out-of-range id gives
// one result with bad_id. The next item is taken in the cycle after the
// last result is loaded, so a new item is not taken before the last is done.
// The output register lets a new item be taken while a result waits; when
// rsp stalls, the list walk holds at the next source found until the
// register drains.
// Reset (rst_n low, asynchronous) clears the present bits and the counter
// and sets node_count to 16; the cost memory is not cleared, and its data is
// only used where the present bit is set.
`timescale 1ns / 1ps

module link_table_with_alpha_beta_cost_unit (
    input  logic           clk,
    input  logic           rst_n,
    ltab_cfg_if.sink       cfg,
    ltab_req_if.sink       req,
    ltab_rsp_if.source     rsp
);
    import ltab_pkg::*;

    // sequencer and table state
    state_t                 state_reg, state_next;
    logic [ENTRIES-1:0]     link_bits_reg;
    logic [PROD_W-1:0]      cost_mem [ENTRIES];
    logic [PROD_W-1:0]      cost_rd_reg;
    logic [CNT_W-1:0]       node_count_reg;
    logic [TOTAL_W-1:0]     link_counter_reg, link_counter_next;

    // operation context
    logic [NODE_W-1:0]      src_reg, src_next;
    logic [NODE_W-1:0]      dst_reg, dst_next;
    logic [COST_W-1:0]      alpha_reg, alpha_next;
    logic [COST_W-1:0]      beta_reg, beta_next;
    logic [COST_W-1:0]      chunk_reg, chunk_next;
    logic                   present_reg, present_next;
    logic [NODE_W-1:0]      walk_reg, walk_next;
    logic [NODE_W-1:0]      pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;

    // pending result
    logic                   res_present_reg, res_present_next;
    logic [TIME_W-1:0]      res_time_reg, res_time_next;
    logic [NODE_W-1:0]      res_src_reg, res_src_next;
    logic                   res_bad_reg, res_bad_next;

    // output register
    logic                   out_valid_reg;
    logic                   out_present_reg;
    logic [TIME_W-1:0]      out_time_reg;
    logic [NODE_W-1:0]      out_src_reg;
    logic [TOTAL_W-1:0]     out_total_reg;
    logic                   out_bad_reg;
    logic                   out_last_reg;

    // combinational controls
    logic [CNT_W-1:0]       n_eff;
    logic                   src_bad, dst_bad;
    logic                   wr_en;
    logic [ENTRY_W-1:0]     wr_idx;
    logic [PROD_W-1:0]      wr_data;
    logic                   rd_en;
    logic [ENTRY_W-1:0]     rd_idx;
    logic                   can_load;
    logic                   load;
    logic                   ld_present;
    logic [TIME_W-1:0]      ld_time;
    logic [NODE_W-1:0]      ld_src;
    logic                   ld_bad;
    logic                   ld_last;
    logic                   hit;
    logic                   at_end;
    logic                   stall;
    cost_req_t              cost_req;
    cost_rsp_t              cost_rsp;

    // node count limited to 1..MAX_NODES
    always_comb
    begin
        if (node_count_reg == '0)
            n_eff = CNT_W'(1);
        else if (node_count_reg > CNT_W'(MAX_NODES))
            n_eff = CNT_W'(MAX_NODES);
        else
            n_eff = node_count_reg;
    end

    assign src_bad  = CNT_W'(req.source_node) >= n_eff;
    assign dst_bad  = CNT_W'(req.target_node) >= n_eff;
    assign can_load = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    // list walk helpers
    assign hit    = link_bits_reg[{walk_reg, dst_reg}];
    assign at_end = (CNT_W'(walk_reg) + CNT_W'(1)) == n_eff;
    assign stall  = hit && pend_valid_reg && !can_load;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        alpha_next       = alpha_reg;
        beta_next        = beta_reg;
        chunk_next       = chunk_reg;
        present_next     = present_reg;
        walk_next        = walk_reg;
        pend_next        = pend_reg;
        pend_valid_next  = pend_valid_reg;
        res_present_next = res_present_reg;
        res_time_next    = res_time_reg;
        res_src_next     = res_src_reg;
        res_bad_next     = res_bad_reg;
        wr_en            = 1'b0;
        wr_idx           = {req.source_node, req.target_node};
        wr_data          = {req.fixed_latency, req.per_unit_cost};
        rd_en            = 1'b0;
        rd_idx           = {req.source_node, req.target_node};
        load             = 1'b0;
        ld_present       = res_present_reg;
        ld_time          = res_time_reg;
        ld_src           = res_src_reg;
        ld_bad           = res_bad_reg;
        ld_last          = 1'b1;
        cost_req.valid   = 1'b0;
        cost_req.alpha   = cost_rd_reg[PROD_W-1:COST_W];
        cost_req.beta    = cost_rd_reg[COST_W-1:0];
        cost_req.chunk   = chunk_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_present_next = 1'b0;
                    res_time_next    = '0;
                    res_src_next     = '0;
                    res_bad_next     = 1'b0;
                    case (req.operation)
                        OP_CONNECT:
                        begin
                            if (src_bad || dst_bad)
                            begin
                                res_bad_next = 1'b1;
                                state_next   = ST_EMIT;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                src_next   = req.source_node;
                                dst_next   = req.target_node;
                                alpha_next = req.fixed_latency;
                                beta_next  = req.per_unit_cost;
                                state_next = req.both_ways ? ST_CONN2 : ST_EMIT;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (src_bad || dst_bad)
                            begin
                                res_bad_next = 1'b1;
                                state_next   = ST_EMIT;
                            end
                            else
                            begin
                                rd_en        = 1'b1;
                                present_next = link_bits_reg[{req.source_node,
                                                              req.target_node}];
                                chunk_next   = req.chunk_units;
                                state_next   = ST_QREAD;
                            end
                        end
                        OP_LIST:
                        begin
                            if (dst_bad)
                            begin
                                res_bad_next = 1'b1;
                                state_next   = ST_EMIT;
                            end
                            else
                            begin
                                dst_next        = req.target_node;
                                walk_next       = '0;
                                pend_valid_next = 1'b0;
                                state_next      = ST_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // reverse direction of a two-way connect
            ST_CONN2:
            begin
                wr_en      = 1'b1;
                wr_idx     = {dst_reg, src_reg};
                wr_data    = {alpha_reg, beta_reg};
                state_next = ST_EMIT;
            end

            // cost data is in the read register
            ST_QREAD:
            begin
                cost_req.valid = 1'b1;
                state_next     = ST_QWAIT;
            end

            ST_QWAIT:
            begin
                if (cost_rsp.valid)
                begin
                    res_present_next = present_reg;
                    res_time_next    = present_reg ? cost_rsp.xfer_time : '0;
                    state_next       = ST_EMIT;
                end
            end

            // one source per cycle unless rsp stalls; a found source waits until the next is known
            ST_LIST:
            begin
                if (!stall)
                begin
                    if (hit && pend_valid_reg)
                    begin
                        load       = 1'b1;
                        ld_present = 1'b1;
                        ld_time    = '0;
                        ld_src     = pend_reg;
                        ld_bad     = 1'b0;
                        ld_last    = 1'b0;
                    end
                    if (hit)
                    begin
                        pend_next       = walk_reg;
                        pend_valid_next = 1'b1;
                    end
                    if (at_end)
                    begin
                        res_present_next = pend_valid_next;
                        res_src_next     = pend_valid_next ? pend_next : '0;
                        state_next       = ST_EMIT;
                    end
                    else
                    begin
                        walk_next = walk_reg + NODE_W'(1);
                    end
                end
            end

            ST_EMIT:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // saturating link counter
    always_comb
    begin
        link_counter_next = link_counter_reg;
        if (wr_en && (link_counter_reg != TOTAL_MAX))
            link_counter_next = link_counter_reg + TOTAL_W'(1);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            link_counter_reg <= '0;
            node_count_reg   <= CNT_W'(MAX_NODES);
            link_bits_reg    <= '0;
            pend_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            link_counter_reg <= link_counter_next;
            pend_valid_reg   <= pend_valid_next;
            if (cfg.valid)
            begin
                node_count_reg <= cfg.node_count;
                link_bits_reg  <= '0;
            end
            else if (wr_en)
            begin
                link_bits_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // operation context and pending result
    always_ff @(posedge clk)
    begin
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        alpha_reg       <= alpha_next;
        beta_reg        <= beta_next;
        chunk_reg       <= chunk_next;
        present_reg     <= present_next;
        walk_reg        <= walk_next;
        pend_reg        <= pend_next;
        res_present_reg <= res_present_next;
        res_time_reg    <= res_time_next;
        res_src_reg     <= res_src_next;
        res_bad_reg     <= res_bad_next;
    end

    // cost memory: alpha in the upper half, beta in the lower
    always_ff @(posedge clk)
    begin
        if (wr_en)
            cost_mem[wr_idx] <= wr_data;
        if (rd_en)
            cost_rd_reg <= cost_mem[rd_idx];
    end

    // multiply and saturating add
    ltab_cost u_cost (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (cost_req),
        .result  (cost_rsp)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_present_reg <= ld_present;
            out_time_reg    <= ld_time;
            out_src_reg     <= ld_src;
            out_total_reg   <= link_counter_reg;
            out_bad_reg     <= ld_bad;
            out_last_reg    <= ld_last;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.link_present  = out_present_reg;
    assign rsp.transfer_time = out_time_reg;
    assign rsp.found_source  = out_src_reg;
    assign rsp.link_total    = out_total_reg;
    assign rsp.bad_id        = out_bad_reg;
    assign rsp.last_result   = out_last_reg;

endmodule
